[rtl/i2p_pkg.sv]
// ----------------------------------------------------------------------------
// i2p_pkg
// Shared types and character codes for the infix to postfix converter.
// ----------------------------------------------------------------------------
package i2p_pkg;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_MOD   = 8'h25;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
    localparam logic [1:0] ERR_UNMATCHED = 2'd2;

    typedef enum logic [1:0] {
        CLS_OPERAND = 2'd0,
        CLS_OPEN    = 2'd1,
        CLS_CLOSE   = 2'd2,
        CLS_OPER    = 2'd3
    } char_class_t;

    typedef struct packed {
        logic [7:0]  ch;
        logic        last;
        char_class_t cls;
        logic        hi_prec;
    } item_t;

    function automatic logic is_low_prec(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS);
    endfunction

endpackage

[rtl/i2p_if.sv]
// ----------------------------------------------------------------------------
// i2p_if
// Valid/ready channels for infix characters in and postfix results out.
// ----------------------------------------------------------------------------
interface i2p_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       end_of_expr;

    modport source (output valid, output in_char, output end_of_expr, input ready);
    modport sink   (input valid, input in_char, input end_of_expr, output ready);
endinterface

interface i2p_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       char_valid;
    logic       last_of_run;
    logic       expr_done;
    logic [1:0] error_code;

    modport source (output valid, output out_char, output char_valid,
                    output last_of_run, output expr_done, output error_code,
                    input ready);
    modport sink   (input valid, input out_char, input char_valid,
                    input last_of_run, input expr_done, input error_code,
                    output ready);
endinterface

[rtl/i2p_ram.sv]
// ----------------------------------------------------------------------------
// i2p_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module i2p_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/i2p_front.sv]
// ----------------------------------------------------------------------------
// i2p_front
// Accepts infix characters, classifies them and holds them in a two-entry
// queue for the stack engine.
// ----------------------------------------------------------------------------
module i2p_front
    import i2p_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    i2p_in_if.sink in_ch,
    output logic  q_valid,
    output item_t q_item,
    input  logic  q_pop
);

    item_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    item_t      new_item;
    logic       push;

    always_comb
    begin
        new_item.ch      = in_ch.in_char;
        new_item.last    = in_ch.end_of_expr;
        new_item.hi_prec = !is_low_prec(in_ch.in_char);
        if (in_ch.in_char == CH_OPEN)
        begin
            new_item.cls = CLS_OPEN;
        end
        else if (in_ch.in_char == CH_CLOSE)
        begin
            new_item.cls = CLS_CLOSE;
        end
        else if (in_ch.in_char == CH_PLUS || in_ch.in_char == CH_MINUS
                 || in_ch.in_char == CH_MUL || in_ch.in_char == CH_DIV
                 || in_ch.in_char == CH_MOD)
        begin
            new_item.cls = CLS_OPER;
        end
        else
        begin
            new_item.cls = CLS_OPERAND;
        end
    end

    assign in_ch.ready = (fill_reg != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;
    assign q_valid     = (fill_reg != 2'd0);
    assign q_item      = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_reg + 2'(push) - 2'(q_pop);
        end
    end

endmodule

[rtl/i2p_back.sv]
// ----------------------------------------------------------------------------
// i2p_back
// Stack engine: pushes and pops the operator stack one entry per step and
// drives the registered result channel, holding one result back so that
// the last result of each item can be marked.
// ----------------------------------------------------------------------------
module i2p_back
    import i2p_pkg::*;
#(
    parameter int STACK_DEPTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  item_t          q_item,
    output logic           q_pop,
    i2p_out_if.source      out_ch
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_STEP  = 5'b00010,
        S_LOAD  = 5'b00100,
        S_FLUSH = 5'b01000,
        S_FIN   = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic        ret_flush_reg, ret_flush_next;
    logic        ret_fin_reg, ret_fin_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] open_reg, open_next;
    logic [7:0]  top_reg, top_next;
    item_t       item_reg, item_next;
    logic [1:0]  err_reg, err_next;
    logic        pend_valid_reg, pend_valid_next;
    logic [7:0]  pend_char_reg, pend_char_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_char_reg, out_char_next;
    logic        out_cv_reg, out_cv_next;
    logic        out_last_reg, out_last_next;
    logic        out_done_reg, out_done_next;
    logic [1:0]  out_err_reg, out_err_next;

    logic        can_send;
    logic        produce;
    logic [7:0]  produce_char;
    logic        do_pop;
    logic        snd;
    logic [7:0]  snd_char;
    logic        snd_cv;
    logic        snd_last;
    logic        full;
    logic        top_stays;
    logic        ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic [7:0]  ram_rdata;

    i2p_ram #(
        .WIDTH(8),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(item_reg.ch),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign can_send  = !out_valid_reg || out_ch.ready;
    assign full      = (cnt_reg == CW'(STACK_DEPTH));
    assign ram_waddr = cnt_reg[AW-1:0];
    assign ram_raddr = AW'(cnt_reg - CW'(2));

    always_comb
    begin
        state_next      = state_reg;
        ret_flush_next  = ret_flush_reg;
        ret_fin_next    = ret_fin_reg;
        cnt_next        = cnt_reg;
        open_next       = open_reg;
        top_next        = top_reg;
        item_next       = item_reg;
        err_next        = err_reg;
        pend_valid_next = pend_valid_reg;
        pend_char_next  = pend_char_reg;
        q_pop           = 1'b0;
        produce         = 1'b0;
        produce_char    = top_reg;
        do_pop          = 1'b0;
        snd             = 1'b0;
        snd_char        = pend_char_reg;
        snd_cv          = 1'b1;
        snd_last        = 1'b0;
        ram_we          = 1'b0;
        top_stays       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    state_next = S_STEP;
                    err_next   = ERR_NONE;
                    if (q_item.cls == CLS_CLOSE && open_reg == '0)
                    begin
                        err_next = ERR_UNMATCHED;
                    end
                    else if (q_item.cls == CLS_OPEN && full)
                    begin
                        err_next = ERR_OVERFLOW;
                    end
                    else if (q_item.cls == CLS_OPER && full
                             && (top_reg == CH_OPEN
                                 || (is_low_prec(top_reg) && q_item.hi_prec)))
                    begin
                        err_next = ERR_OVERFLOW;
                    end
                end
            end
            S_STEP:
            begin
                if (can_send)
                begin
                    case (item_reg.cls)
                        CLS_OPERAND:
                        begin
                            produce      = 1'b1;
                            produce_char = item_reg.ch;
                            top_stays    = 1'b1;
                        end
                        CLS_OPEN:
                        begin
                            top_stays = 1'b1;
                            if (!full)
                            begin
                                ram_we    = 1'b1;
                                top_next  = item_reg.ch;
                                cnt_next  = cnt_reg + CW'(1);
                                open_next = open_reg + CW'(1);
                            end
                        end
                        CLS_CLOSE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                top_stays = 1'b1;
                            end
                            else if (top_reg == CH_OPEN)
                            begin
                                do_pop    = 1'b1;
                                top_stays = 1'b1;
                            end
                            else
                            begin
                                produce = 1'b1;
                                do_pop  = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (cnt_reg == '0 || top_reg == CH_OPEN
                                || (is_low_prec(top_reg) && item_reg.hi_prec))
                            begin
                                top_stays = 1'b1;
                                if (!full)
                                begin
                                    ram_we   = 1'b1;
                                    top_next = item_reg.ch;
                                    cnt_next = cnt_reg + CW'(1);
                                end
                            end
                            else
                            begin
                                produce = 1'b1;
                                do_pop  = 1'b1;
                            end
                        end
                    endcase
                    ret_flush_next = 1'b0;
                    if (top_stays)
                    begin
                        state_next = item_reg.last ? S_FLUSH : S_FIN;
                    end
                    else
                    begin
                        state_next = S_STEP;
                    end
                end
            end
            S_LOAD:
            begin
                top_next     = ram_rdata;
                ret_fin_next = 1'b0;
                if (ret_flush_reg)
                begin
                    state_next = S_FLUSH;
                end
                else if (ret_fin_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_STEP;
                end
            end
            S_FLUSH:
            begin
                if (can_send)
                begin
                    ret_flush_next = 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        produce = (top_reg != CH_OPEN) && (top_reg != CH_CLOSE);
                        do_pop  = 1'b1;
                    end
                end
            end
            S_FIN:
            begin
                if (can_send)
                begin
                    state_next      = S_IDLE;
                    pend_valid_next = 1'b0;
                    snd_last        = 1'b1;
                    if (pend_valid_reg)
                    begin
                        snd = 1'b1;
                    end
                    else if (item_reg.last || err_reg != ERR_NONE)
                    begin
                        snd      = 1'b1;
                        snd_char = 8'h00;
                        snd_cv   = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (do_pop)
        begin
            cnt_next = cnt_reg - CW'(1);
            if (top_reg == CH_OPEN)
            begin
                open_next = open_reg - CW'(1);
            end
            if (cnt_reg > CW'(1))
            begin
                state_next = S_LOAD;
                if (state_reg == S_STEP && item_reg.cls == CLS_CLOSE
                    && top_reg == CH_OPEN)
                begin
                    ret_flush_next = item_reg.last;
                    ret_fin_next   = !item_reg.last;
                end
            end
            else if (state_reg == S_FLUSH)
            begin
                state_next = S_FLUSH;
            end
            else if (item_reg.cls == CLS_CLOSE && top_reg == CH_OPEN)
            begin
                state_next = item_reg.last ? S_FLUSH : S_FIN;
            end
            else
            begin
                state_next = S_STEP;
            end
        end

        if (produce)
        begin
            if (pend_valid_reg)
            begin
                snd = 1'b1;
            end
            pend_valid_next = 1'b1;
            pend_char_next  = produce_char;
        end

        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_cv_next    = out_cv_reg;
        out_last_next  = out_last_reg;
        out_done_next  = out_done_reg;
        out_err_next   = out_err_reg;
        if (snd)
        begin
            out_valid_next = 1'b1;
            out_char_next  = snd_char;
            out_cv_next    = snd_cv;
            out_last_next  = snd_last;
            out_done_next  = snd_last && item_reg.last;
            out_err_next   = err_reg;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg       <= top_next;
        item_reg      <= item_next;
        err_reg       <= err_next;
        pend_char_reg <= pend_char_next;
        out_char_reg  <= out_char_next;
        out_cv_reg    <= out_cv_next;
        out_last_reg  <= out_last_next;
        out_done_reg  <= out_done_next;
        out_err_reg   <= out_err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_flush_reg  <= 1'b0;
            ret_fin_reg    <= 1'b0;
            cnt_reg        <= '0;
            open_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_flush_reg  <= ret_flush_next;
            ret_fin_reg    <= ret_fin_next;
            cnt_reg        <= cnt_next;
            open_reg       <= open_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.out_char    = out_char_reg;
    assign out_ch.char_valid  = out_cv_reg;
    assign out_ch.last_of_run = out_last_reg;
    assign out_ch.expr_done   = out_done_reg;
    assign out_ch.error_code  = out_err_reg;

endmodule

[rtl/infix_to_postfix_converter.sv]
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard infix to postfix converter with an operator stack in RAM.
//
// in_ch carries one infix byte per transfer with end_of_expr on the final
// byte; out_ch carries postfix results (out_char, char_valid, last_of_run,
// expr_done, error_code), one or more per input transfer or none.
// A two-entry queue takes input transfers while the stack engine works.
// An operand passes through take, step and finish states; the end of an
// expression adds a flush state, and each stack pop adds a load state, in
// which the registered read of the stack RAM fetches the new top entry,
// unless the pop empties the stack.
// The engine holds one result back to mark the last of each run, so a
// result leaves once the next is known or the run ends.
// Reset empties the stack and the queue and drops any held result; no
// clearing pass runs. When out_ch stalls, the engine and then the queue
// hold, and in_ch.ready falls once the queue is full.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter
    import i2p_pkg::*;
#(
    parameter int STACK_DEPTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    i2p_in_if.sink     in_ch,
    i2p_out_if.source  out_ch
);

    logic  q_valid;
    item_t q_item;
    logic  q_pop;

    i2p_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .q_valid(q_valid),
        .q_item (q_item),
        .q_pop  (q_pop)
    );

    i2p_back #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_valid(q_valid),
        .q_item (q_item),
        .q_pop  (q_pop),
        .out_ch (out_ch)
    );

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Checks the infix to postfix converter against a shunting-yard predictor
// kept in the bench: infix bytes go in over in_ch with random gaps, postfix
// results come back over out_ch with random stalls, and every result is
// compared field by field with the oldest one predicted.
// ----------------------------------------------------------------------------
module testbench
    import i2p_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = 32;
    localparam int RAND_ITEMS = 100;
    localparam int CALM_TAIL  = 20;

    typedef struct {
        logic [7:0] ch;
        logic       eoe;
    } infix_item_t;

    typedef struct {
        logic [7:0] ch;
        logic       cv;
        logic       last;
        logic       done;
        logic [1:0] err;
    } postfix_t;

    logic clk;
    logic rst_n;

    i2p_in_if  in_ch ();
    i2p_out_if out_ch ();

    infix_to_postfix_converter #(
        .STACK_DEPTH (DEPTH)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    infix_item_t infix_feed [$];
    postfix_t    postfix_due [$];
    logic [7:0]  run_chars [$];
    logic [7:0]  op_stack [DEPTH];
    int          op_count;
    int          mismatches;
    bit          in_fire;
    int          src_gap;
    int          snk_gap;

    function automatic bit is_arith(input logic [7:0] c);
        return c == CH_PLUS || c == CH_MINUS || c == CH_MUL || c == CH_DIV || c == CH_MOD;
    endfunction

    function automatic int op_rank(input logic [7:0] c);
        return (c == CH_PLUS || c == CH_MINUS) ? 1 : 2;
    endfunction

    function automatic bit stack_push(input logic [7:0] c);
        if (op_count >= DEPTH)
        begin
            return 1'b0;
        end
        op_stack[op_count] = c;
        op_count++;
        return 1'b1;
    endfunction

    function automatic logic [7:0] pick_special();
        case ($urandom_range(0, 6))
            0: return CH_PLUS;
            1: return CH_MINUS;
            2: return CH_MUL;
            3: return CH_DIV;
            4: return CH_MOD;
            5: return CH_OPEN;
            default: return CH_CLOSE;
        endcase
    endfunction

    function automatic logic [7:0] pick_operand();
        logic [7:0] c;
        if ($urandom_range(0, 5) == 0)
        begin
            return 8'h20;
        end
        do
        begin
            c = 8'($urandom_range(0, 255));
        end
        while (is_arith(c) || c == CH_OPEN || c == CH_CLOSE);
        return c;
    endfunction

    function automatic logic [7:0] pick_arith();
        logic [7:0] c;
        do
        begin
            c = pick_special();
        end
        while (!is_arith(c));
        return c;
    endfunction

    task automatic feed(input logic [7:0] c, input logic eoe);
        infix_item_t it;
        it.ch  = c;
        it.eoe = eoe;
        infix_feed.push_back(it);
    endtask

    task automatic feed_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            feed(s[i], i == s.len() - 1);
        end
    endtask

    task automatic convert_char(input logic [7:0] c, input logic eoe);
        logic [1:0] err;
        logic [7:0] t;
        postfix_t   r;
        err = ERR_NONE;
        run_chars.delete();
        if (c == CH_OPEN)
        begin
            if (!stack_push(c))
                err = ERR_OVERFLOW;
        end
        else if (c == CH_CLOSE)
        begin
            while (op_count > 0 && op_stack[op_count - 1] != CH_OPEN)
            begin
                run_chars.push_back(op_stack[op_count - 1]);
                op_count--;
            end
            if (op_count > 0)
                op_count--;
            else
                err = ERR_UNMATCHED;
        end
        else if (is_arith(c))
        begin
            while (op_count > 0)
            begin
                t = op_stack[op_count - 1];
                if (t == CH_OPEN || op_rank(t) < op_rank(c))
                    break;
                run_chars.push_back(t);
                op_count--;
            end
            if (!stack_push(c))
                err = ERR_OVERFLOW;
        end
        else
        begin
            run_chars.push_back(c);
        end

        if (eoe)
        begin
            while (op_count > 0)
            begin
                t = op_stack[op_count - 1];
                if (t != CH_OPEN && t != CH_CLOSE)
                    run_chars.push_back(t);
                op_count--;
            end
        end

        if (run_chars.size() == 0)
        begin
            if (eoe || err != ERR_NONE)
            begin
                r.ch   = 8'h00;
                r.cv   = 1'b0;
                r.last = 1'b1;
                r.done = eoe;
                r.err  = err;
                postfix_due.push_back(r);
            end
        end
        else
        begin
            for (int i = 0; i < run_chars.size(); i++)
            begin
                r.ch   = run_chars[i];
                r.cv   = 1'b1;
                r.last = (i == run_chars.size() - 1);
                r.done = eoe && r.last;
                r.err  = err;
                postfix_due.push_back(r);
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // predict on each input transfer, then check each output transfer
    always @(posedge clk)
    begin : monitor
        postfix_t want;
        in_fire = 1'b0;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                in_fire = 1'b1;
                convert_char(in_ch.in_char, in_ch.end_of_expr);
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (postfix_due.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, got char %02h cv %b last %b done %b err %0d",
                             $time, out_ch.out_char, out_ch.char_valid, out_ch.last_of_run,
                             out_ch.expr_done, out_ch.error_code);
                    mismatches++;
                end
                else
                begin
                    want = postfix_due.pop_front();
                    if (out_ch.out_char !== want.ch || out_ch.char_valid !== want.cv
                        || out_ch.last_of_run !== want.last || out_ch.expr_done !== want.done
                        || out_ch.error_code !== want.err)
                    begin
                        $display("%0t: expected char %02h cv %b last %b done %b err %0d",
                                 $time, want.ch, want.cv, want.last, want.done, want.err);
                        $display("%0t:      got char %02h cv %b last %b done %b err %0d",
                                 $time, out_ch.out_char, out_ch.char_valid, out_ch.last_of_run,
                                 out_ch.expr_done, out_ch.error_code);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(negedge clk)
    begin : driver
        infix_item_t it;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else if (in_ch.valid && !in_fire)
        begin
            // hold until the transfer
        end
        else if (src_gap > 0)
        begin
            in_ch.valid <= 1'b0;
            src_gap--;
        end
        else if (infix_feed.size() > 0)
        begin
            it = infix_feed.pop_front();
            in_ch.valid       <= 1'b1;
            in_ch.in_char     <= it.ch;
            in_ch.end_of_expr <= it.eoe;
            if (infix_feed.size() >= CALM_TAIL && $urandom_range(0, 3) == 0)
                src_gap = $urandom_range(1, 13);
        end
        else
        begin
            in_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin : sink
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else if (snk_gap > 0)
        begin
            out_ch.ready <= 1'b0;
            snk_gap--;
        end
        else
        begin
            out_ch.ready <= 1'b1;
            if (infix_feed.size() >= CALM_TAIL && $urandom_range(0, 5) == 0)
                snk_gap = $urandom_range(1, 13);
        end
    end

    initial
    begin : stimulus
        infix_item_t expr [$];
        int          pick;
        int          deep_runs;
        int          n;
        int          opened;
        int          directed;
        bit          prev_open;

        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.in_char     = 8'h00;
        in_ch.end_of_expr = 1'b0;
        out_ch.ready      = 1'b0;
        op_count          = 0;
        mismatches        = 0;
        src_gap           = 0;
        snk_gap           = 0;
        deep_runs         = 0;

        feed_text("a+b*c");
        feed_text("(x-y)/z%w");
        feed(CH_CLOSE, 1'b1);
        feed(CH_PLUS, 1'b0);
        feed(CH_CLOSE, 1'b0);
        feed(CH_OPEN, 1'b1);
        feed(CH_OPEN, 1'b0);
        feed(CH_MUL, 1'b0);
        feed(8'hFF, 1'b1);
        feed(8'h00, 1'b1);
        feed_text("()");
        directed = infix_feed.size();

        while (infix_feed.size() < directed + RAND_ITEMS)
        begin
            expr.delete();
            pick = $urandom_range(0, 19);
            if (deep_runs == 0 && infix_feed.size() > directed + 60)
                pick = 0;
            if (pick == 0 && deep_runs < 2)
            begin
                // fill the stack past its depth, then flush
                deep_runs++;
                n = DEPTH + $urandom_range(1, 3);
                prev_open = 1'b0;
                for (int k = 0; k < n; k++)
                begin
                    if (prev_open && $urandom_range(0, 1) == 1)
                    begin
                        expr.push_back('{pick_arith(), 1'b0});
                        prev_open = 1'b0;
                    end
                    else
                    begin
                        expr.push_back('{CH_OPEN, 1'b0});
                        prev_open = 1'b1;
                    end
                end
                n = $urandom_range(0, 2);
                for (int k = 0; k < n; k++)
                    expr.push_back('{CH_CLOSE, 1'b0});
                expr.push_back('{pick_operand(), 1'b1});
            end
            else if (pick < 5)
            begin
                n = $urandom_range(1, 5);
                for (int k = 0; k < n; k++)
                begin
                    if ($urandom_range(0, 1) == 1)
                        expr.push_back('{pick_special(), 1'b0});
                    else
                        expr.push_back('{8'($urandom_range(0, 255)), 1'b0});
                end
                expr[$].eoe = 1'($urandom_range(0, 1));
            end
            else
            begin
                n = $urandom_range(1, 6);
                opened = 0;
                for (int k = 0; k < n; k++)
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        expr.push_back('{CH_OPEN, 1'b0});
                        opened++;
                    end
                    expr.push_back('{pick_operand(), 1'b0});
                    if (opened > 0 && $urandom_range(0, 2) == 0)
                    begin
                        expr.push_back('{CH_CLOSE, 1'b0});
                        opened--;
                    end
                    if (k < n - 1)
                        expr.push_back('{pick_arith(), 1'b0});
                end
                if ($urandom_range(0, 1) == 1)
                begin
                    while (opened > 0)
                    begin
                        expr.push_back('{CH_CLOSE, 1'b0});
                        opened--;
                    end
                end
                expr[$].eoe = 1'b1;
            end
            foreach (expr[i])
                infix_feed.push_back(expr[i]);
        end

        repeat (12) @(posedge clk);
        #2 rst_n = 1'b1;

        while (infix_feed.size() != 0 || in_ch.valid)
            @(posedge clk);
        while (postfix_due.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[sim.f]
rtl/i2p_pkg.sv
rtl/i2p_if.sv
rtl/i2p_ram.sv
rtl/i2p_front.sv
rtl/i2p_back.sv
rtl/infix_to_postfix_converter.sv
dv/testbench.sv
